>>> rtl/core/depth_background_target_centroid_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the depth background target centroid block
// Shared concurrent assertion forms, clocked on the rising edge and held off in reset.
// ----------------------------------------------------------------------------
`ifndef DEPTH_BACKGROUND_TARGET_CENTROID_MACROS_SVH
`define DEPTH_BACKGROUND_TARGET_CENTROID_MACROS_SVH

// Same-cycle implication.
`define DBTC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dbtc assertion failed");

// Next-cycle implication.
`define DBTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dbtc assertion failed");

`endif

>>> rtl/core/dbtc_pkg.sv
// ----------------------------------------------------------------------------
// Depth background target centroid package
// Widths, codes, reset values, zone coordinate tables and shared types.
// ----------------------------------------------------------------------------
package dbtc_pkg;

    localparam int ZONE_COUNT = 64;
    localparam int GRID_WIDTH = 8;
    localparam int ROW_COUNT  = ZONE_COUNT / GRID_WIDTH;
    localparam int MAX_COORD  = ((GRID_WIDTH > ROW_COUNT) ? GRID_WIDTH : ROW_COUNT) - 1;

    localparam int ZONE_W    = 6;
    localparam int ZONE_AW   = $clog2(ZONE_COUNT);
    localparam int COL_W     = $clog2(GRID_WIDTH);
    localparam int ROW_W     = $clog2(ROW_COUNT);
    localparam int DIST_W    = 12;
    localparam int STATUS_W  = 8;
    localparam int TARGETS_W = 4;
    localparam int MASK_W    = 64;
    localparam int OUT_W     = 8;
    localparam int HIT_W     = 7;
    localparam int CNT_W     = $clog2(ZONE_COUNT + 1);
    localparam int SUM_W     = $clog2(ZONE_COUNT * MAX_COORD + 1);
    localparam int STEP_W    = $clog2(SUM_W);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_THRESHOLD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZONE_ENABLE_MASK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_BACKGROUND = 2'd2;

    localparam logic MODE_CAPTURE = 1'b0;
    localparam logic MODE_DETECT  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK_A = 8'd5;
    localparam logic [STATUS_W-1:0] STATUS_OK_B = 8'd9;

    localparam logic [DIST_W-1:0] THR_RESET   = 12'd200;
    localparam logic [MASK_W-1:0] MASK_RESET  = 64'h3C7E_FFFF_FFFF_7E3C;
    localparam logic [DIST_W-1:0] EMPTY_RESET = 12'd2550;
    localparam logic [OUT_W-1:0]  NONE_CODE   = 8'hFF;

    typedef logic [ZONE_COUNT-1:0][COL_W-1:0] t_col_tab;
    typedef logic [ZONE_COUNT-1:0][ROW_W-1:0] t_row_tab;

    function automatic t_col_tab f_col_tab();
        t_col_tab tab;
        for (int k = 0; k < ZONE_COUNT; k++) begin
            tab[k] = COL_W'(k % GRID_WIDTH);
        end
        return tab;
    endfunction

    function automatic t_row_tab f_row_tab();
        t_row_tab tab;
        for (int k = 0; k < ZONE_COUNT; k++) begin
            tab[k] = ROW_W'(k / GRID_WIDTH);
        end
        return tab;
    endfunction

    localparam t_col_tab COL_TAB = f_col_tab();
    localparam t_row_tab ROW_TAB = f_row_tab();

    typedef struct packed {
        logic [DIST_W-1:0] near_threshold;
        logic [MASK_W-1:0] zone_enable_mask;
        logic [DIST_W-1:0] empty_background;
    } t_cfg;

    typedef struct packed {
        logic [SUM_W-1:0] column_sum;
        logic [SUM_W-1:0] row_sum;
        logic [CNT_W-1:0] hit_count;
    } t_job;

endpackage

>>> rtl/core/dbtc_front.sv
// ----------------------------------------------------------------------------
// Zone front end
// Accepts zones, keeps the background store, finds hits and queues frame sums.
// ----------------------------------------------------------------------------
`include "depth_background_target_centroid_macros.svh"

module dbtc_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_mode,
    input  logic [dbtc_pkg::ZONE_W-1:0]      i_zone_index,
    input  logic [dbtc_pkg::DIST_W-1:0]      i_zone_distance,
    input  logic [dbtc_pkg::STATUS_W-1:0]    i_zone_status,
    input  logic [dbtc_pkg::TARGETS_W-1:0]   i_zone_targets,
    input  logic                             i_last_zone,
    input  dbtc_pkg::t_cfg                   i_cfg,
    output logic                             o_push,
    output dbtc_pkg::t_job                   o_job,
    input  logic                             i_q_full
);
    import dbtc_pkg::*;

    logic                  r_s1_vld;
    logic                  r_s1_mode;
    logic [ZONE_W-1:0]     r_s1_zone;
    logic [DIST_W-1:0]     r_s1_dist;
    logic                  r_s1_ok;
    logic                  r_s1_last;

    logic [DIST_W-1:0]     r_bg_mem [ZONE_COUNT];
    logic [ZONE_COUNT-1:0] r_bg_vld;
    logic [DIST_W-1:0]     r_bg_rd;
    logic                  r_rd_vld;
    logic                  r_rd_fwd;
    logic [DIST_W-1:0]     r_fwd_data;

    logic [CNT_W-1:0]      r_hit_cnt;
    logic [SUM_W-1:0]      r_col_sum;
    logic [SUM_W-1:0]      r_row_sum;
    logic [CNT_W-1:0]      n_hit_cnt;
    logic [SUM_W-1:0]      n_col_sum;
    logic [SUM_W-1:0]      n_row_sum;

    logic                  in_acc;
    logic                  zone_ok;
    logic                  s1_end;
    logic                  s1_go;
    logic                  s1_fire;
    logic                  in_range;
    logic [ZONE_AW-1:0]    wr_addr;
    logic [ZONE_AW-1:0]    rd_addr;
    logic                  bg_write;
    logic [DIST_W-1:0]     bg_wdata;
    logic [DIST_W-1:0]     bg_cur;
    logic [DIST_W:0]       diff;
    logic                  hit;

    assign zone_ok  = (i_zone_status inside {STATUS_OK_A, STATUS_OK_B}) && (i_zone_targets != '0);
    assign s1_end   = r_s1_vld && (r_s1_mode == MODE_DETECT) && r_s1_last;
    assign s1_go    = !s1_end || !i_q_full;
    assign s1_fire  = r_s1_vld && s1_go;
    assign o_in_stall = r_s1_vld && !s1_go;
    assign in_acc   = i_in_valid && !o_in_stall;

    assign in_range = {1'b0, r_s1_zone} < (ZONE_W + 1)'(ZONE_COUNT);
    assign wr_addr  = r_s1_zone[ZONE_AW-1:0];
    assign rd_addr  = i_zone_index[ZONE_AW-1:0];
    assign bg_write = s1_fire && (r_s1_mode == MODE_CAPTURE) && in_range;
    assign bg_wdata = r_s1_ok ? r_s1_dist : i_cfg.empty_background;

    assign bg_cur = r_rd_fwd ? r_fwd_data : (r_rd_vld ? r_bg_rd : '0);
    assign diff   = {1'b0, bg_cur} - {1'b0, r_s1_dist};
    assign hit    = s1_fire && (r_s1_mode == MODE_DETECT) && in_range
                    && i_cfg.zone_enable_mask[r_s1_zone] && r_s1_ok
                    && !diff[DIST_W] && (diff[DIST_W-1:0] > i_cfg.near_threshold)
                    && (r_hit_cnt < CNT_W'(ZONE_COUNT));

    always_comb begin
        n_hit_cnt = r_hit_cnt;
        n_col_sum = r_col_sum;
        n_row_sum = r_row_sum;
        if (hit) begin
            n_hit_cnt = r_hit_cnt + CNT_W'(1);
            n_col_sum = r_col_sum + SUM_W'(COL_TAB[wr_addr]);
            n_row_sum = r_row_sum + SUM_W'(ROW_TAB[wr_addr]);
        end
    end

    assign o_push            = s1_fire && s1_end;
    assign o_job.column_sum  = n_col_sum;
    assign o_job.row_sum     = n_row_sum;
    assign o_job.hit_count   = n_hit_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_bg_vld  <= '0;
            r_hit_cnt <= '0;
            r_col_sum <= '0;
            r_row_sum <= '0;
        end else begin
            if (in_acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_fire) begin
                r_s1_vld <= 1'b0;
            end
            if (bg_write) begin
                r_bg_vld[wr_addr] <= 1'b1;
            end
            if (o_push) begin
                r_hit_cnt <= '0;
                r_col_sum <= '0;
                r_row_sum <= '0;
            end else begin
                r_hit_cnt <= n_hit_cnt;
                r_col_sum <= n_col_sum;
                r_row_sum <= n_row_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_mode <= i_mode;
            r_s1_zone <= i_zone_index;
            r_s1_dist <= i_zone_distance;
            r_s1_ok   <= zone_ok;
            r_s1_last <= i_last_zone;
        end
    end

    // The store is read as a zone enters; a write by the zone ahead to the same
    // entry in that cycle is forwarded.
    always_ff @(posedge i_clk) begin
        if (bg_write) begin
            r_bg_mem[wr_addr] <= bg_wdata;
        end
        if (in_acc) begin
            r_bg_rd    <= r_bg_mem[rd_addr];
            r_rd_vld   <= r_bg_vld[rd_addr];
            r_rd_fwd   <= bg_write && (wr_addr == rd_addr);
            r_fwd_data <= bg_wdata;
        end
    end

    `DBTC_ASSERT_IMPL(a_push_room, i_clk, i_rst_n, o_push, !i_q_full)
    `DBTC_ASSERT_NEXT(a_sums_clear, i_clk, i_rst_n, o_push, {r_hit_cnt, r_col_sum, r_row_sum} == '0)
    `DBTC_ASSERT_IMPL(a_hit_bound, i_clk, i_rst_n, 1'b1, r_hit_cnt <= CNT_W'(ZONE_COUNT))

endmodule

>>> rtl/core/dbtc_queue.sv
// ----------------------------------------------------------------------------
// Frame job queue
// Short first-in first-out buffer of frame sums between front and back end.
// ----------------------------------------------------------------------------
`include "depth_background_target_centroid_macros.svh"

module dbtc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dbtc_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output dbtc_pkg::t_job o_job
);
    import dbtc_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_cnt;

    assign o_full  = r_cnt == QCNT_W'(QUEUE_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    `DBTC_ASSERT_IMPL(a_pop_nonempty, i_clk, i_rst_n, i_pop, r_cnt != '0)

endmodule

>>> rtl/core/dbtc_back.sv
// ----------------------------------------------------------------------------
// Centroid back end
// Divides the frame sums by the hit count one bit a cycle and holds the result.
// ----------------------------------------------------------------------------
`include "depth_background_target_centroid_macros.svh"

module dbtc_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dbtc_pkg::t_job                i_job,
    input  logic                          i_empty,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [dbtc_pkg::OUT_W-1:0]    o_target_column,
    output logic [dbtc_pkg::OUT_W-1:0]    o_target_row,
    output logic [dbtc_pkg::OUT_W-1:0]    o_target_zone,
    output logic                          o_target_state,
    output logic [dbtc_pkg::HIT_W-1:0]    o_hit_total
);
    import dbtc_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [STEP_W-1:0] r_step;
    logic [CNT_W-1:0]  r_den;
    logic [SUM_W-1:0]  r_quo_c;
    logic [SUM_W-1:0]  r_quo_r;
    logic [CNT_W-1:0]  r_rem_c;
    logic [CNT_W-1:0]  r_rem_r;

    logic              r_out_vld;
    logic [OUT_W-1:0]  r_col;
    logic [OUT_W-1:0]  r_row;
    logic [OUT_W-1:0]  r_zone;
    logic              r_tstate;
    logic [HIT_W-1:0]  r_total;

    logic [CNT_W:0]    rem_c_sh;
    logic [CNT_W:0]    rem_r_sh;
    logic              ge_c;
    logic              ge_r;
    logic [CNT_W:0]    sub_c;
    logic [CNT_W:0]    sub_r;
    logic              out_free;
    logic              load;
    logic [OUT_W-1:0]  col_q;
    logic [OUT_W-1:0]  row_q;

    assign rem_c_sh = {r_rem_c, r_quo_c[SUM_W-1]};
    assign rem_r_sh = {r_rem_r, r_quo_r[SUM_W-1]};
    assign ge_c     = rem_c_sh >= {1'b0, r_den};
    assign ge_r     = rem_r_sh >= {1'b0, r_den};
    assign sub_c    = ge_c ? (rem_c_sh - {1'b0, r_den}) : rem_c_sh;
    assign sub_r    = ge_r ? (rem_r_sh - {1'b0, r_den}) : rem_r_sh;

    assign out_free = !r_out_vld || !i_out_stall;
    assign o_pop    = (r_state == ST_IDLE) && !i_empty;
    assign load     = (r_state == ST_DONE) && out_free;
    assign col_q    = OUT_W'(r_quo_c);
    assign row_q    = OUT_W'(r_quo_r);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_step == STEP_W'(SUM_W - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_step  <= '0;
            r_den   <= i_job.hit_count;
            r_quo_c <= i_job.column_sum;
            r_quo_r <= i_job.row_sum;
            r_rem_c <= '0;
            r_rem_r <= '0;
        end else if (r_state == ST_DIV) begin
            r_step  <= r_step + STEP_W'(1);
            r_quo_c <= {r_quo_c[SUM_W-2:0], ge_c};
            r_quo_r <= {r_quo_r[SUM_W-2:0], ge_r};
            r_rem_c <= sub_c[CNT_W-1:0];
            r_rem_r <= sub_r[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_total <= HIT_W'(r_den);
            if (r_den == '0) begin
                r_col    <= NONE_CODE;
                r_row    <= NONE_CODE;
                r_zone   <= NONE_CODE;
                r_tstate <= 1'b0;
            end else begin
                r_col    <= col_q;
                r_row    <= row_q;
                r_zone   <= col_q + row_q * OUT_W'(GRID_WIDTH);
                r_tstate <= 1'b1;
            end
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_target_column = r_col;
    assign o_target_row    = r_row;
    assign o_target_zone   = r_zone;
    assign o_target_state  = r_tstate;
    assign o_hit_total     = r_total;

    `DBTC_ASSERT_IMPL(a_step_range, i_clk, i_rst_n, r_state == ST_DIV, r_step < STEP_W'(SUM_W))

endmodule

>>> rtl/core/depth_background_target_centroid.sv
// ----------------------------------------------------------------------------
// Depth background target centroid
// Background subtraction over a zone grid with a per-frame hit centroid.
//
// Channel   Direction  Handshake                  Payload
// zone      in         i_in_valid / o_in_stall    mode, index, distance, status, targets, last
// centroid  out        o_out_valid / i_out_stall  column, row, zone, state, hit total
// config    in         i_cfg_we                   i_cfg_index, i_cfg_data
//
// A zone is taken every cycle while not stalled and is evaluated from the stage
// register once accepted. The bit-serial divider takes one frame job at a time.
// Two frame jobs can wait in the queue; the zone input stalls only on a frame end
// request while the queue is full.
// Reset clears the background valid bits at once, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module depth_background_target_centroid (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_mode,
    input  logic [dbtc_pkg::ZONE_W-1:0]      i_zone_index,
    input  logic [dbtc_pkg::DIST_W-1:0]      i_zone_distance,
    input  logic [dbtc_pkg::STATUS_W-1:0]    i_zone_status,
    input  logic [dbtc_pkg::TARGETS_W-1:0]   i_zone_targets,
    input  logic                             i_last_zone,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [dbtc_pkg::OUT_W-1:0]       o_target_column,
    output logic [dbtc_pkg::OUT_W-1:0]       o_target_row,
    output logic [dbtc_pkg::OUT_W-1:0]       o_target_zone,
    output logic                             o_target_state,
    output logic [dbtc_pkg::HIT_W-1:0]       o_hit_total,
    input  logic                             i_cfg_we,
    input  logic [dbtc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [dbtc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import dbtc_pkg::*;

    t_cfg r_cfg;
    t_job front_job;
    t_job queue_job;
    logic push;
    logic q_full;
    logic pop;
    logic q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.near_threshold   <= THR_RESET;
            r_cfg.zone_enable_mask <= MASK_RESET;
            r_cfg.empty_background <= EMPTY_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_NEAR_THRESHOLD: begin
                    r_cfg.near_threshold <= i_cfg_data[DIST_W-1:0];
                end
                CFG_ZONE_ENABLE_MASK: begin
                    r_cfg.zone_enable_mask <= i_cfg_data[MASK_W-1:0];
                end
                CFG_EMPTY_BACKGROUND: begin
                    r_cfg.empty_background <= i_cfg_data[DIST_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    dbtc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_mode          (i_mode),
        .i_zone_index    (i_zone_index),
        .i_zone_distance (i_zone_distance),
        .i_zone_status   (i_zone_status),
        .i_zone_targets  (i_zone_targets),
        .i_last_zone     (i_last_zone),
        .i_cfg           (r_cfg),
        .o_push          (push),
        .o_job           (front_job),
        .i_q_full        (q_full)
    );

    dbtc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_job   (queue_job)
    );

    dbtc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job           (queue_job),
        .i_empty         (q_empty),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_target_column (o_target_column),
        .o_target_row    (o_target_row),
        .o_target_zone   (o_target_zone),
        .o_target_state  (o_target_state),
        .o_hit_total     (o_hit_total)
    );

endmodule
